/* src/qpt_pkg.sv */
// qpt_pkg: shared constants, register indexes and types for the quadrant
// photodiode tracking control block
// no dependencies
package qpt_pkg;

  // default fixed point layout of the filter state
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int FRACTION_BITS_DEF = 16;

  // port widths
  localparam int SAMPLE_IN_W = 10;
  localparam int ALPHA_W     = 16;
  localparam int GAIN_W      = 12;
  localparam int DB_W        = 11;
  localparam int MAX_STEPS_W = 8;
  localparam int THR_W       = 11;
  localparam int TGT_W       = 12;
  localparam int ERR_OUT_W   = 12;
  localparam int POWER_OUT_W = 12;
  localparam int STEP_W      = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // gain is Q4.8, saturated at 10.0
  localparam int GAIN_FRAC_BITS = 8;
  localparam logic [GAIN_W-1:0] GAIN_LIMIT = 12'd2560;

  // register reset values
  localparam logic [ALPHA_W-1:0]     ALPHA_RST     = 16'd3277;
  localparam logic [GAIN_W-1:0]      GAIN_RST      = 12'd256;
  localparam logic [DB_W-1:0]        DEADBAND_RST  = 11'd10;
  localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST = 8'd50;
  localparam logic [THR_W-1:0]       THR_RST       = 11'd15;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_ALPHA = 3'd0,
    REG_GAIN_X       = 3'd1,
    REG_GAIN_Y       = 3'd2,
    REG_DEADBAND     = 3'd3,
    REG_MAX_STEPS    = 3'd4,
    REG_CONV_THR     = 3'd5,
    REG_AUTO_ENABLE  = 3'd6
  } cfg_reg_t;

  // sequencer strobes to the filter lanes
  typedef struct packed {
    logic diff_en;
    logic mult_en;
    logic upd_en;
  } lane_ctrl_t;

endpackage

/* src/qpt_filter_lane.sv */
// qpt_filter_lane: one quadrant's exponential filter, three strobed steps
// (difference, split multiply, accumulate)
// depends on qpt_pkg
module qpt_filter_lane #(
  parameter int SAMPLE_BITS   = qpt_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = qpt_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  qpt_pkg::lane_ctrl_t             ctrl,
  input  logic [qpt_pkg::ALPHA_W-1:0]     alpha,
  input  logic [qpt_pkg::SAMPLE_IN_W-1:0] sample,
  output logic [SAMPLE_BITS-1:0]          q
);

  localparam int AW   = qpt_pkg::ALPHA_W;
  localparam int FW   = SAMPLE_BITS + FRACTION_BITS;
  localparam int DW   = FW + 1;
  localparam int HW   = DW - AW;
  localparam int PHW  = HW + AW + 1;
  localparam int SUMW = FW + 3;

  logic [FW-1:0]          f;
  logic signed [DW-1:0]   d;
  logic [2*AW-1:0]        p_lo;
  logic signed [PHW-1:0]  p_hi;

  logic [SAMPLE_BITS-1:0] s;
  logic signed [DW-1:0]   d_next;
  logic [2*AW-1:0]        p_lo_next;
  logic signed [PHW-1:0]  p_hi_next;
  logic [SUMW-1:0]        sum;

  // f' = f + floor(alpha * ((s << F) - f) / 2^16), product split at bit 16
  always_comb begin
    s         = (SAMPLE_BITS)'(sample);
    d_next    = $signed({1'b0, s, {FRACTION_BITS{1'b0}}}) - $signed({1'b0, f});
    p_lo_next = {{AW{1'b0}}, alpha} * {{AW{1'b0}}, d[AW-1:0]};
    p_hi_next = $signed({1'b0, alpha}) * $signed(d[DW-1:AW]);
    sum       = {3'b000, f}
              + {{(SUMW-PHW){p_hi[PHW-1]}}, p_hi}
              + {{(SUMW-AW){1'b0}}, p_lo[2*AW-1:AW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f <= '0;
    end else if (ctrl.upd_en) begin
      f <= sum[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      d <= d_next;
    end
    if (ctrl.mult_en) begin
      p_lo <= p_lo_next;
      p_hi <= p_hi_next;
    end
  end

  assign q = f[FW-1:FRACTION_BITS];

endmodule

/* src/qpt_axis.sv */
// qpt_axis: per-axis deadband, gain multiply, truncation toward zero and
// clamp; also the converged compare for that axis
// depends on qpt_pkg
module qpt_axis #(
  parameter int REL_W = 14
) (
  input  logic                            clk,
  input  logic                            ld,
  input  logic signed [REL_W-1:0]         rel,
  input  logic                            act,
  input  logic [qpt_pkg::GAIN_W-1:0]      gain,
  input  logic [qpt_pkg::DB_W-1:0]        deadband,
  input  logic [qpt_pkg::MAX_STEPS_W-1:0] max_steps,
  input  logic [qpt_pkg::THR_W-1:0]       threshold,
  output logic signed [qpt_pkg::STEP_W-1:0] step,
  output logic                            move,
  output logic                            near
);

  localparam int GW = qpt_pkg::GAIN_W;
  localparam int MW = qpt_pkg::MAX_STEPS_W;
  localparam int PW = REL_W + GW + 1;
  localparam int FB = qpt_pkg::GAIN_FRAC_BITS;

  logic signed [PW-1:0] prod;
  logic                 active;
  logic                 near_r;

  logic [REL_W-1:0]     abs_rel;
  logic [GW-1:0]        gsat;
  logic [PW-1:0]        abs_prod;
  logic [PW-FB-1:0]     mag;
  logic [MW-1:0]        mag_c;

  always_comb begin
    abs_rel  = rel[REL_W-1] ? REL_W'(-rel) : REL_W'(rel);
    gsat     = (gain > qpt_pkg::GAIN_LIMIT) ? qpt_pkg::GAIN_LIMIT : gain;
    abs_prod = prod[PW-1] ? PW'(-prod) : PW'(prod);
    mag      = abs_prod[PW-1:FB];
    mag_c    = (mag > (PW-FB)'(max_steps)) ? max_steps : mag[MW-1:0];
    if (!active) begin
      step = '0;
    end else if (prod[PW-1]) begin
      step = -$signed({1'b0, mag_c});
    end else begin
      step = $signed({1'b0, mag_c});
    end
  end

  // first stage: compares and the product, second stage is the output logic
  always_ff @(posedge clk) begin
    if (ld) begin
      prod   <= $signed({1'b0, gsat}) * rel;
      active <= act && (abs_rel > REL_W'(deadband));
      near_r <= abs_rel < REL_W'(threshold);
    end
  end

  assign move = active;
  assign near = near_r;

endmodule

/* src/quad_photodiode_tracking_control.sv */
// quad_photodiode_tracking_control: top level, sequencer, configuration
// registers, merge of the four filter lanes, target and result register
// depends on qpt_pkg, qpt_filter_lane, qpt_axis
//
// usage
//   input channel: in_valid / in_stall carry one sample set (four quadrant
//   samples, control_tick, target_toggle) per transaction
//   output channel: out_valid / out_stall carry one result per input:
//   filtered errors, total power, step requests, move flags, converged
//   config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   the register, cfg_data holds the value in its low bits; unknown indexes
//   are ignored; write only while no transaction is in flight
//   latency: 7 cycles from the accepting edge to out_valid
//   throughput: one set every 8 cycles; four parallel filter lanes take three
//   steps (difference, split multiply, accumulate), then merge, target and
//   two axis stages follow, one item in flight at a time
//   in_stall is high while an item is in flight; a finished result waits in
//   the output register, so a stalled receiver only holds the block when the
//   next result is ready and the previous one has not been taken
//   reset: filter state and target cleared, registers back to their
//   defaults, output register empty
module quad_photodiode_tracking_control #(
  parameter int SAMPLE_BITS   = qpt_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = qpt_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [qpt_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [qpt_pkg::SAMPLE_IN_W-1:0]   sample_a,
  input  logic [qpt_pkg::SAMPLE_IN_W-1:0]   sample_b,
  input  logic [qpt_pkg::SAMPLE_IN_W-1:0]   sample_c,
  input  logic [qpt_pkg::SAMPLE_IN_W-1:0]   sample_d,
  input  logic                              control_tick,
  input  logic                              target_toggle,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qpt_pkg::ERR_OUT_W-1:0] error_x,
  output logic signed [qpt_pkg::ERR_OUT_W-1:0] error_y,
  output logic [qpt_pkg::POWER_OUT_W-1:0]   total_power,
  output logic signed [qpt_pkg::STEP_W-1:0] step_x,
  output logic signed [qpt_pkg::STEP_W-1:0] step_y,
  output logic                              move_x,
  output logic                              move_y,
  output logic                              converged
);

  localparam int SIN = qpt_pkg::SAMPLE_IN_W;
  localparam int TW  = qpt_pkg::TGT_W;
  // error width follows the filtered sample width; relative error width is the wider of error and target, plus one
  localparam int EW  = SAMPLE_BITS + 3;
  localparam int PWR = SAMPLE_BITS + 2;
  localparam int RW  = ((EW > TW) ? EW : TW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MULT,
    ST_UPD,
    ST_MERGE,
    ST_TGT,
    ST_AXIS,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [qpt_pkg::ALPHA_W-1:0]     filter_alpha;
  logic [qpt_pkg::GAIN_W-1:0]      gain_x;
  logic [qpt_pkg::GAIN_W-1:0]      gain_y;
  logic [qpt_pkg::DB_W-1:0]        deadband;
  logic [qpt_pkg::MAX_STEPS_W-1:0] max_steps;
  logic [qpt_pkg::THR_W-1:0]       conv_thresh;
  logic                            auto_enable;

  // captured input set
  logic [SIN-1:0] smp_a;
  logic [SIN-1:0] smp_b;
  logic [SIN-1:0] smp_c;
  logic [SIN-1:0] smp_d;
  logic           tick;
  logic           toggle;

  // merge results, target, relative errors
  logic signed [EW-1:0] ex;
  logic signed [EW-1:0] ey;
  logic [PWR-1:0]       tp;
  logic signed [TW-1:0] target_x;
  logic signed [TW-1:0] target_y;
  logic signed [RW-1:0] rel_x;
  logic signed [RW-1:0] rel_y;
  logic                 act;

  logic signed [TW-1:0] target_x_next;
  logic signed [TW-1:0] target_y_next;

  qpt_pkg::lane_ctrl_t  lane_ctrl;
  logic [SAMPLE_BITS-1:0] q_a;
  logic [SAMPLE_BITS-1:0] q_b;
  logic [SAMPLE_BITS-1:0] q_c;
  logic [SAMPLE_BITS-1:0] q_d;

  logic                 axis_ld;
  logic signed [qpt_pkg::STEP_W-1:0] ax_step_x;
  logic signed [qpt_pkg::STEP_W-1:0] ax_step_y;
  logic                 ax_move_x;
  logic                 ax_move_y;
  logic                 near_x;
  logic                 near_y;

  logic in_accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha <= qpt_pkg::ALPHA_RST;
      gain_x       <= qpt_pkg::GAIN_RST;
      gain_y       <= qpt_pkg::GAIN_RST;
      deadband     <= qpt_pkg::DEADBAND_RST;
      max_steps    <= qpt_pkg::MAX_STEPS_RST;
      conv_thresh  <= qpt_pkg::THR_RST;
      auto_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qpt_pkg::REG_FILTER_ALPHA: filter_alpha <= cfg_data[qpt_pkg::ALPHA_W-1:0];
        qpt_pkg::REG_GAIN_X:       gain_x <= cfg_data[qpt_pkg::GAIN_W-1:0];
        qpt_pkg::REG_GAIN_Y:       gain_y <= cfg_data[qpt_pkg::GAIN_W-1:0];
        qpt_pkg::REG_DEADBAND:     deadband <= cfg_data[qpt_pkg::DB_W-1:0];
        qpt_pkg::REG_MAX_STEPS:    max_steps <= cfg_data[qpt_pkg::MAX_STEPS_W-1:0];
        qpt_pkg::REG_CONV_THR:     conv_thresh <= cfg_data[qpt_pkg::THR_W-1:0];
        qpt_pkg::REG_AUTO_ENABLE:  auto_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // four filter lanes, one per quadrant
  always_comb begin
    lane_ctrl.diff_en = (state == ST_DIFF);
    lane_ctrl.mult_en = (state == ST_MULT);
    lane_ctrl.upd_en  = (state == ST_UPD);
  end

  qpt_filter_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_a (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .alpha(filter_alpha), .sample(smp_a), .q(q_a)
  );
  qpt_filter_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_b (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .alpha(filter_alpha), .sample(smp_b), .q(q_b)
  );
  qpt_filter_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_c (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .alpha(filter_alpha), .sample(smp_c), .q(q_c)
  );
  qpt_filter_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_lane_d (
    .clk(clk), .rst(rst), .ctrl(lane_ctrl), .alpha(filter_alpha), .sample(smp_d), .q(q_d)
  );

  // toggle: capture when no target is set, otherwise clear
  always_comb begin
    target_x_next = target_x;
    target_y_next = target_y;
    if (toggle) begin
      if (target_x == '0 && target_y == '0) begin
        target_x_next = TW'(ex);
        target_y_next = TW'(ey);
      end else begin
        target_x_next = '0;
        target_y_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
    end else if (state == ST_TGT) begin
      target_x <= target_x_next;
      target_y <= target_y_next;
    end
  end

  // two axis lanes
  assign axis_ld = (state == ST_AXIS);

  qpt_axis #(.REL_W(RW)) u_axis_x (
    .clk(clk), .ld(axis_ld), .rel(rel_x), .act(act), .gain(gain_x),
    .deadband(deadband), .max_steps(max_steps), .threshold(conv_thresh),
    .step(ax_step_x), .move(ax_move_x), .near(near_x)
  );
  qpt_axis #(.REL_W(RW)) u_axis_y (
    .clk(clk), .ld(axis_ld), .rel(rel_y), .act(act), .gain(gain_y),
    .deadband(deadband), .max_steps(max_steps), .threshold(conv_thresh),
    .step(ax_step_y), .move(ax_move_y), .near(near_y)
  );

  // sequencer, merge and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in the final step the result register is either held or reloaded
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            smp_a  <= sample_a;
            smp_b  <= sample_b;
            smp_c  <= sample_c;
            smp_d  <= sample_d;
            tick   <= control_tick;
            toggle <= target_toggle;
            state  <= ST_DIFF;
          end
        end
        ST_DIFF: state <= ST_MULT;
        ST_MULT: state <= ST_UPD;
        ST_UPD:  state <= ST_MERGE;
        ST_MERGE: begin
          // right minus left, top minus bottom, sum of all four
          ex    <= $signed(EW'(q_a) + EW'(q_b)) - $signed(EW'(q_c) + EW'(q_d));
          ey    <= $signed(EW'(q_a) + EW'(q_d)) - $signed(EW'(q_b) + EW'(q_c));
          tp    <= PWR'(q_a) + PWR'(q_b) + PWR'(q_c) + PWR'(q_d);
          state <= ST_TGT;
        end
        ST_TGT: begin
          // relative error uses the target after this item's toggle
          rel_x <= RW'(ex) - RW'(target_x_next);
          rel_y <= RW'(ey) - RW'(target_y_next);
          act   <= tick && auto_enable;
          state <= ST_AXIS;
        end
        ST_AXIS: state <= ST_DONE;
        ST_DONE: begin
          // hold here until the result register is free
          if (out_free) begin
            out_valid   <= 1'b1;
            error_x     <= qpt_pkg::ERR_OUT_W'(ex);
            error_y     <= qpt_pkg::ERR_OUT_W'(ey);
            total_power <= qpt_pkg::POWER_OUT_W'(tp);
            step_x      <= ax_step_x;
            step_y      <= -ax_step_y;
            move_x      <= ax_move_x;
            move_y      <= ax_move_y;
            converged   <= near_x && near_y;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a new result only comes out of the final step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result register loaded outside the final step");

  // a finished result is not dropped while the receiver stalls
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("sequencer left the final step with the result register full");

  // an accepted set starts the filter lanes next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DIFF))
    else $error("accepted transaction did not start the filter lanes");

  // no move means no step on either axis
  a_no_move_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((move_x || step_x == '0) && (move_y || step_y == '0)))
    else $error("step request without a move flag");

endmodule
